FILE: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the sound unit, all reset-qualified.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// prop must hold at every clock edge outside reset
`define DPSU_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// expr must never be true outside reset
`define DPSU_ASSERT_NEVER(label, clk, rst_n, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

FILE: hdl/dpsu_pkg.sv
// ----------------------------------------------------------------------------
// dpsu_pkg
// Types, register map and tables for the dual pulse sound unit.
// ----------------------------------------------------------------------------
package dpsu_pkg;

	localparam int QFC_DEFAULT = 7457;

	// period counter range is -1023 .. 4096
	localparam int PC_W = 14;

	localparam logic [4:0] REG_CH0_CTRL = 5'h00;
	localparam logic [4:0] REG_CH0_PLO  = 5'h02;
	localparam logic [4:0] REG_CH0_PHI  = 5'h03;
	localparam logic [4:0] REG_CH1_CTRL = 5'h04;
	localparam logic [4:0] REG_CH1_PLO  = 5'h06;
	localparam logic [4:0] REG_CH1_PHI  = 5'h07;
	localparam logic [4:0] REG_RAW      = 5'h11;
	localparam logic [4:0] REG_ENABLE   = 5'h15;

	localparam logic [7:0] LENGTH_TABLE [32] = '{
		8'h0A, 8'hFE, 8'h14, 8'h02, 8'h28, 8'h04, 8'h50, 8'h06,
		8'hA0, 8'h08, 8'h3C, 8'h0A, 8'h0E, 8'h0C, 8'h1A, 8'h0E,
		8'h0C, 8'h10, 8'h18, 8'h12, 8'h30, 8'h14, 8'h60, 8'h16,
		8'hC0, 8'h18, 8'h48, 8'h1A, 8'h10, 8'h1C, 8'h20, 8'h1E
	};

	// one bit per duty step, set where the output is high
	localparam logic [7:0] DUTY_PATTERN [4] = '{
		8'b0000_0010, 8'b0000_0110, 8'b0001_1110, 8'b1111_1001
	};

	typedef struct packed {
		logic       ctrl;
		logic       plo;
		logic       phi;
		logic       en_wr;
		logic       en_val;
		logic [7:0] data;
	} chan_wr_t;

	typedef struct packed {
		logic wr;
		logic start;
		logic frame;
		logic step;
		logic load_out;
	} dp_cmd_t;

	typedef struct packed {
		logic pending;
	} dp_status_t;

endpackage

FILE: hdl/dpsu_ctrl.sv
// ----------------------------------------------------------------------------
// dpsu_ctrl
// Sequencer: accepts transactions, walks the sample phases, owns m_tvalid.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dpsu_ctrl
	import dpsu_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic       func,
	output logic       m_tvalid,
	input  logic       m_tready,
	output dp_cmd_t    cmd,
	input  dp_status_t status
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_FRAME,
		ST_LOOP,
		ST_DONE
	} state_t;

	state_t state_q;
	logic   m_tvalid_q;
	logic   out_free;
	logic   accept;

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign accept   = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;

	always_comb begin
		cmd          = '0;
		cmd.wr       = accept && !func;
		cmd.start    = accept && func;
		cmd.frame    = (state_q == ST_FRAME);
		cmd.step     = (state_q == ST_LOOP);
		cmd.load_out = (state_q == ST_DONE) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			m_tvalid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept && func)
						state_q <= ST_FRAME;
				end
				ST_FRAME: state_q <= ST_LOOP;
				ST_LOOP: begin
					if (!status.pending)
						state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase

			if (cmd.load_out)
				m_tvalid_q <= 1'b1;
			else if (m_tready)
				m_tvalid_q <= 1'b0;
		end
	end

	`DPSU_ASSERT(a_valid_from_done, clk, arst_n, $rose(m_tvalid_q) |-> $past(state_q == ST_DONE), "result raised outside done phase")
	`DPSU_ASSERT(a_loop_exit, clk, arst_n, (state_q == ST_LOOP) && !status.pending |=> state_q == ST_DONE, "duty loop did not finish")

endmodule

FILE: hdl/dpsu_chan.sv
// ----------------------------------------------------------------------------
// dpsu_chan
// One pulse channel: registers, duty sequencer, envelope and length counter.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dpsu_chan
	import dpsu_pkg::*;
#(
	parameter int QUARTER_FRAME_CYCLES = QFC_DEFAULT
) (
	input  logic              clk,
	input  logic              arst_n,
	input  chan_wr_t          wr,
	input  logic              start,
	input  logic              frame,
	input  logic              step,
	input  logic [9:0]        cycles,
	output logic              pending,
	output logic signed [6:0] level
);

	localparam int FC_W = $clog2(QUARTER_FRAME_CYCLES + 1) + 1;

	logic [3:0]             vol_q;
	logic                   cvol_q;
	logic                   hold_q;
	logic [1:0]             duty_q;
	logic [10:0]            period_q;
	logic [2:0]             step_q;
	logic [8:0]             len_q;
	logic [4:0]             envdiv_q;
	logic [3:0]             envlvl_q;
	logic                   enabled_q;
	logic                   restart_q;
	logic                   run_q;
	logic signed [PC_W-1:0] pc_q;
	logic signed [FC_W-1:0] fc_q;

	logic                   active;
	logic [3:0]             cur_vol;
	logic signed [6:0]      mag;
	logic signed [PC_W-1:0] step_amt;
	logic [4:0]             div_dec;
	logic [4:0]             div_reload;
	logic                   qf_due;

	assign active     = (|period_q[10:3]) && (len_q != 9'd0);
	assign cur_vol    = cvol_q ? vol_q : envlvl_q;
	assign mag        = $signed({1'b0, cur_vol, 2'b00});
	assign step_amt   = $signed(PC_W'({({1'b0, period_q} + 12'd1), 1'b0}));
	assign div_dec    = envdiv_q - 5'd1;
	assign div_reload = {1'b0, vol_q} + 5'd1;
	assign qf_due     = fc_q[FC_W-1] || (fc_q == '0);
	assign pending    = run_q && (pc_q[PC_W-1] || (pc_q == '0));

	always_comb begin
		if (!run_q || !active)
			level = '0;
		else if (DUTY_PATTERN[duty_q][step_q])
			level = mag;
		else
			level = -mag;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vol_q     <= '0;
			cvol_q    <= 1'b0;
			hold_q    <= 1'b0;
			duty_q    <= '0;
			period_q  <= '0;
			step_q    <= '0;
			len_q     <= '0;
			envdiv_q  <= '0;
			envlvl_q  <= '0;
			enabled_q <= 1'b0;
			restart_q <= 1'b0;
			run_q     <= 1'b0;
			pc_q      <= '0;
			fc_q      <= '0;
		end else begin
			if (wr.ctrl) begin
				vol_q  <= wr.data[3:0];
				cvol_q <= wr.data[4];
				hold_q <= wr.data[5];
				duty_q <= wr.data[7:6];
			end
			if (wr.plo)
				period_q[7:0] <= wr.data;
			if (wr.phi) begin
				period_q[10:8] <= wr.data[2:0];
				if (enabled_q)
					len_q <= {LENGTH_TABLE[wr.data[7:3]], 1'b0};
				step_q    <= '0;
				restart_q <= 1'b1;
			end
			if (wr.en_wr) begin
				enabled_q <= wr.en_val;
				if (!wr.en_val)
					len_q <= '0;
			end

			// sample start: when enabled and active, take both counters down by the elapsed cycles
			if (start) begin
				run_q <= enabled_q && active;
				if (enabled_q && active) begin
					pc_q <= pc_q - $signed(PC_W'(cycles));
					fc_q <= fc_q - $signed(FC_W'(cycles));
				end
			end

			// at most one quarter frame per sample since the quarter-frame period exceeds 1023
			if (frame && run_q && qf_due) begin
				fc_q <= fc_q + $signed(FC_W'(QUARTER_FRAME_CYCLES));
				if (restart_q) begin
					restart_q <= 1'b0;
					envlvl_q  <= 4'hF;
					envdiv_q  <= div_reload;
				end else if (div_dec == 5'd0) begin
					envdiv_q <= div_reload;
					if (envlvl_q != 4'd0)
						envlvl_q <= envlvl_q - 4'd1;
					else
						envlvl_q <= hold_q ? 4'hF : 4'h0;
				end else begin
					envdiv_q <= div_dec;
				end
				if ((len_q != 9'd0) && !hold_q)
					len_q <= len_q - 9'd1;
			end

			if (step && pending) begin
				pc_q   <= pc_q + step_amt;
				step_q <= step_q + 3'd1;
			end
		end
	end

	`DPSU_ASSERT(a_fc_settled, clk, arst_n, frame && run_q |=> fc_q > 0, "quarter-frame counter not positive after frame phase")
	`DPSU_ASSERT(a_fc_bound, clk, arst_n, fc_q <= $signed(FC_W'(QUARTER_FRAME_CYCLES)), "quarter-frame counter above reload")

endmodule

FILE: hdl/dpsu_datapath.sv
// ----------------------------------------------------------------------------
// dpsu_datapath
// Register decode, the two channel lanes, raw level and the output mixer.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dpsu_datapath
	import dpsu_pkg::*;
#(
	parameter int QUARTER_FRAME_CYCLES = QFC_DEFAULT
) (
	input  logic        clk,
	input  logic        arst_n,
	input  dp_cmd_t     cmd,
	output dp_status_t  status,
	input  logic [4:0]  reg_offset,
	input  logic [7:0]  wdata,
	input  logic [9:0]  cycles,
	output logic [15:0] sample
);

	chan_wr_t          wr_c [2];
	logic              pend_c [2];
	logic signed [6:0] level_c [2];
	logic [7:0]        raw_q;
	logic [15:0]       sample_q;
	logic signed [9:0] mix;

	always_comb begin
		wr_c[0]      = '0;
		wr_c[1]      = '0;
		wr_c[0].data = wdata;
		wr_c[1].data = wdata;
		if (cmd.wr) begin
			unique case (reg_offset)
				REG_CH0_CTRL: wr_c[0].ctrl = 1'b1;
				REG_CH0_PLO:  wr_c[0].plo  = 1'b1;
				REG_CH0_PHI:  wr_c[0].phi  = 1'b1;
				REG_CH1_CTRL: wr_c[1].ctrl = 1'b1;
				REG_CH1_PLO:  wr_c[1].plo  = 1'b1;
				REG_CH1_PHI:  wr_c[1].phi  = 1'b1;
				REG_ENABLE: begin
					wr_c[0].en_wr  = 1'b1;
					wr_c[0].en_val = wdata[0];
					wr_c[1].en_wr  = 1'b1;
					wr_c[1].en_val = wdata[1];
				end
				default: ;
			endcase
		end
	end

	for (genvar c = 0; c < 2; c++) begin : g_chan
		dpsu_chan #(
			.QUARTER_FRAME_CYCLES(QUARTER_FRAME_CYCLES)
		) u_chan (
			.clk    (clk),
			.arst_n (arst_n),
			.wr     (wr_c[c]),
			.start  (cmd.start),
			.frame  (cmd.frame),
			.step   (cmd.step),
			.cycles (cycles),
			.pending(pend_c[c]),
			.level  (level_c[c])
		);
	end

	assign status.pending = pend_c[0] || pend_c[1];

	assign mix = $signed({{3{level_c[0][6]}}, level_c[0]})
		+ $signed({{3{level_c[1][6]}}, level_c[1]})
		+ $signed({2'b00, raw_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			raw_q <= '0;
		else if (cmd.wr && (reg_offset == REG_RAW))
			raw_q <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			sample_q <= '0;
		else if (cmd.load_out)
			sample_q <= {mix, 6'b00_0000};
	end

	assign sample = sample_q;

	`DPSU_ASSERT_NEVER(a_load_settled, clk, arst_n, cmd.load_out && status.pending, "sample taken while a duty step is still due")

endmodule

FILE: hdl/dual_pulse_sound_unit.sv
// ----------------------------------------------------------------------------
// dual_pulse_sound_unit
// Two pulse channels with envelope and length counter, plus a raw level.
// ----------------------------------------------------------------------------
// Register-write transaction: s_tready stays high, no result.
// Sample transaction: m_tvalid rises after the frame phase, the duty loop and the
// done phase; the loop runs while either channel still owes a duty step (0 .. 57
// steps), one period add per channel per cycle, and no new transaction is taken
// until the done phase ends. A waiting result stalls only the done phase.
// arst_n clears all channel state, the raw level and the handshake at once.
// ----------------------------------------------------------------------------
module dual_pulse_sound_unit
	import dpsu_pkg::*;
#(
	parameter int QUARTER_FRAME_CYCLES = QFC_DEFAULT
) (
	input  logic        clk,
	input  logic        arst_n,
	// input transactions
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,  // reg_offset[4:0], wdata[12:5], cycles[22:13], zero pad
	input  logic        s_tuser,  // func: 0 register write, 1 advance and emit sample
	// result transactions
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata   // sample[15:0], signed
);

	dp_cmd_t    cmd;
	dp_status_t status;

	// Sequencer: idle -> frame -> loop (until no channel owes a duty step)
	// -> done (load the output register once it is free).
	dpsu_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.func    (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.cmd     (cmd),
		.status  (status)
	);

	// Datapath: the register write lands at the accepting edge; a sample
	// subtracts the elapsed cycles at that edge, then the quarter frame,
	// then the duty steps, then the mix into the output register.
	dpsu_datapath #(
		.QUARTER_FRAME_CYCLES(QUARTER_FRAME_CYCLES)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.reg_offset(s_tdata[4:0]),
		.wdata     (s_tdata[12:5]),
		.cycles    (s_tdata[22:13]),
		.sample    (m_tdata)
	);

endmodule
